[hdl/osd_pkg.sv]
// ----------------------------------------------------------------------------
// osd_pkg
// Shared constants, types and bitmap tables for the level-bar OSD overlay.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package osd_pkg;

   // Default geometry
   localparam int SCREEN_WIDTH_DEF  = 320;
   localparam int SCREEN_HEIGHT_DEF = 240;
   localparam int BAR_COUNT_DEF     = 9;

   // Field widths
   localparam int X_W     = 9;
   localparam int Y_W     = 8;
   localparam int COLOR_W = 16;
   localparam int MODE_W  = 2;
   localparam int LEVEL_W = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   // Overlay modes
   localparam logic [MODE_W-1:0] MODE_NONE       = 2'd0;
   localparam logic [MODE_W-1:0] MODE_VOLUME     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BRIGHTNESS = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MODE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VOLUME     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BRIGHTNESS = 2'd2;

   // Reset values
   localparam logic [LEVEL_W-1:0] VOLUME_RST     = 4'd4;
   localparam logic [LEVEL_W-1:0] BRIGHTNESS_RST = 4'd7;

   // Panel
   localparam int PANEL_X = 265;
   localparam int PANEL_Y = 10;
   localparam int PANEL_W = 39;
   localparam int PANEL_H = 128;
   localparam int CORNER  = 8;

   // Icon
   localparam int ICON_X    = 272;
   localparam int ICON_Y    = 110;
   localparam int ICON_SIZE = 24;

   // Bars
   localparam int BOX_X    = 272;
   localparam int BOX_W    = 25;
   localparam int BOX_Y    = 17;
   localparam int BOX_GAP  = 2;
   localparam int BOX_SPAN = 93;

   // Colors
   localparam logic [COLOR_W-1:0] WHITE     = 16'hFFFF;
   localparam logic [COLOR_W-1:0] DARK_MASK = 16'h7BEF;
   localparam logic [COLOR_W-1:0] DARK_ADD  = 16'h2104;

   typedef struct packed {
      logic panel;
      logic icon;
      logic box;
      logic box_lit;
   } osd_hit_type;

   // Rounded corner coverage, MSB = outermost column
   function automatic logic [CORNER-1:0] corner_bits(input logic [2:0] row);
      logic [CORNER-1:0] bits;
      case (row)
         3'd0:    bits = 8'h01;
         3'd1:    bits = 8'h07;
         3'd2:    bits = 8'h0F;
         3'd3:    bits = 8'h1F;
         3'd4:    bits = 8'h3F;
         3'd5:    bits = 8'h7F;
         3'd6:    bits = 8'h7F;
         default: bits = 8'hFF;
      endcase
      return bits;
   endfunction

   // Speaker icon, one row per entry, MSB = left pixel
   function automatic logic [ICON_SIZE-1:0] speaker_row(input logic [4:0] row);
      logic [ICON_SIZE-1:0] bits;
      case (row)
         5'd1:    bits = 24'h000010;
         5'd2:    bits = 24'h000008;
         5'd3:    bits = 24'h000004;
         5'd4:    bits = 24'h003042;
         5'd5:    bits = 24'h007021;
         5'd6:    bits = 24'h00F011;
         5'd7:    bits = 24'h7FF109;
         5'd8:    bits = 24'hFFF089;
         5'd9:    bits = 24'hFFF049;
         5'd10:   bits = 24'hFFF049;
         5'd11:   bits = 24'hFFF049;
         5'd12:   bits = 24'hFFF049;
         5'd13:   bits = 24'hFFF049;
         5'd14:   bits = 24'hFFF049;
         5'd15:   bits = 24'h7FF089;
         5'd16:   bits = 24'h00F109;
         5'd17:   bits = 24'h007011;
         5'd18:   bits = 24'h003021;
         5'd19:   bits = 24'h000042;
         5'd20:   bits = 24'h000004;
         5'd21:   bits = 24'h000008;
         5'd22:   bits = 24'h000010;
         default: bits = '0;
      endcase
      return bits;
   endfunction

   // Sun icon
   function automatic logic [ICON_SIZE-1:0] sun_row(input logic [4:0] row);
      logic [ICON_SIZE-1:0] bits;
      case (row)
         5'd3:    bits = 24'h000800;
         5'd4:    bits = 24'h000800;
         5'd5:    bits = 24'h020820;
         5'd6:    bits = 24'h010040;
         5'd7:    bits = 24'h008080;
         5'd8:    bits = 24'h001C00;
         5'd9:    bits = 24'h003E00;
         5'd10:   bits = 24'h007F00;
         5'd11:   bits = 24'h0E7F38;
         5'd12:   bits = 24'h007F00;
         5'd13:   bits = 24'h003E00;
         5'd14:   bits = 24'h001C00;
         5'd15:   bits = 24'h008040;
         5'd16:   bits = 24'h010020;
         5'd17:   bits = 24'h020810;
         5'd18:   bits = 24'h000800;
         5'd19:   bits = 24'h000800;
         default: bits = '0;
      endcase
      return bits;
   endfunction

   // Halve each channel and add a grey bias; no channel carries
   function automatic logic [COLOR_W-1:0] darken(input logic [COLOR_W-1:0] c);
      return ((c >> 1) & DARK_MASK) + DARK_ADD;
   endfunction

endpackage

[hdl/osd_level_bar_overlay.sv]
// ----------------------------------------------------------------------------
// osd_level_bar_overlay
// Pipeline: 2 register stages; a req transfer is registered in the input
// stage and then moves into the result register, which drives rsp_tvalid.
// Throughput: one pixel per cycle while rsp_tready is high; the input and
// result registers form a two-entry pipeline, so req_tready stays high while rsp_tready is high.
// Reset: synchronous, active high; clears both valid flags and loads the
// registers to mode none, volume 4, brightness 7.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module osd_level_bar_overlay #(
   parameter int SCREEN_WIDTH  = osd_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = osd_pkg::SCREEN_HEIGHT_DEF,
   parameter int BAR_COUNT     = osd_pkg::BAR_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,

   // Pixel input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [8:0] pixel_x, [16:9] pixel_y, [32:17] pixel_color

   // Composited pixel output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] out_color

   // Register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [osd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [osd_pkg::CSR_DATA_W-1:0]    csr_data
);
   import osd_pkg::*;

   // Control registers
   logic [MODE_W-1:0]  mode_ff,       mode_in;
   logic [LEVEL_W-1:0] volume_ff,     volume_in;
   logic [LEVEL_W-1:0] brightness_ff, brightness_in;

   // Input stage
   logic               s1_valid_ff, s1_valid_in;
   logic [X_W-1:0]     s1_x_ff;
   logic [Y_W-1:0]     s1_y_ff;
   logic [COLOR_W-1:0] s1_color_ff;

   // Result stage
   logic               out_valid_ff, out_valid_in;
   logic [COLOR_W-1:0] out_color_ff;

   logic               req_xfer;
   logic               out_open;
   logic               s1_move;
   osd_hit_type        hit;
   logic [COLOR_W-1:0] blend_color;

   // Register writes are always taken; the user must write only while idle, the block itself does not enforce it
   assign csr_ready = 1'b1;

   always_comb begin
      mode_in       = mode_ff;
      volume_in     = volume_ff;
      brightness_in = brightness_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_MODE:       mode_in       = csr_data[MODE_W-1:0];
            REG_VOLUME:     volume_in     = csr_data[LEVEL_W-1:0];
            REG_BRIGHTNESS: brightness_in = csr_data[LEVEL_W-1:0];
            default: ;      // unmapped index: transfer is dropped
         endcase
      end
   end

   // Result register frees when empty or drained this cycle
   assign out_open   = !out_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_open;
   assign req_tready = !s1_valid_ff || out_open;
   assign req_xfer   = req_tvalid && req_tready;

   assign s1_valid_in  = req_xfer || (s1_valid_ff && !out_open);
   assign out_valid_in = s1_move || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_NONE;
         volume_ff     <= VOLUME_RST;
         brightness_ff <= BRIGHTNESS_RST;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         volume_ff     <= volume_in;
         brightness_ff <= brightness_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_x_ff     <= req_tdata[8:0];
         s1_y_ff     <= req_tdata[16:9];
         s1_color_ff <= req_tdata[32:17];
      end
      if (s1_move) begin
         out_color_ff <= blend_color;
      end
   end

   osd_geom #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .BAR_COUNT     (BAR_COUNT)
   ) u_geom (
      .pixel_x          (s1_x_ff),
      .pixel_y          (s1_y_ff),
      .overlay_mode     (mode_ff),
      .volume_level     (volume_ff),
      .brightness_level (brightness_ff),
      .hit              (hit)
   );

   osd_blend u_blend (
      .pixel_color (s1_color_ff),
      .hit         (hit),
      .out_color   (blend_color)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_color_ff;

endmodule

[hdl/osd_geom.sv]
// ----------------------------------------------------------------------------
// osd_geom
// Region decode: panel, icon and bar-box hits for one pixel coordinate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module osd_geom #(
   parameter int SCREEN_WIDTH  = osd_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = osd_pkg::SCREEN_HEIGHT_DEF,
   parameter int BAR_COUNT     = osd_pkg::BAR_COUNT_DEF
) (
   input  logic [osd_pkg::X_W-1:0]     pixel_x,
   input  logic [osd_pkg::Y_W-1:0]     pixel_y,
   input  logic [osd_pkg::MODE_W-1:0]  overlay_mode,
   input  logic [osd_pkg::LEVEL_W-1:0] volume_level,
   input  logic [osd_pkg::LEVEL_W-1:0] brightness_level,
   output osd_pkg::osd_hit_type        hit
);
   import osd_pkg::*;

   localparam int BOX_PITCH = BOX_SPAN / BAR_COUNT;
   localparam int BOX_H     = BOX_PITCH - BOX_GAP;
   localparam int CW        = 11;   // compare width, covers screen limits up to 2047

   logic [CW-1:0]      x_w;
   logic [CW-1:0]      y_w;
   logic               active;
   logic               is_volume;
   logic [LEVEL_W-1:0] level;

   logic               panel_box;
   logic [5:0]         lx;
   logic [6:0]         ly;
   logic [2:0]         cj;
   logic [2:0]         ci;
   logic               in_cx;
   logic               in_cy;
   logic [CORNER-1:0]  cmask;
   logic               panel_hit;

   logic               icon_box;
   logic [4:0]         ix;
   logic [4:0]         iy;
   logic [4:0]         ibit;
   logic [ICON_SIZE-1:0] irow;

   logic               box_col;
   logic [Y_W-1:0]     off;
   logic [BAR_COUNT-1:0] bar_hits;
   logic [BAR_COUNT-1:0] bar_lit;

   assign x_w = CW'(pixel_x);
   assign y_w = CW'(pixel_y);

   assign is_volume = (overlay_mode == MODE_VOLUME);
   assign active    = (is_volume || overlay_mode == MODE_BRIGHTNESS)
                      && (x_w < CW'(SCREEN_WIDTH)) && (y_w < CW'(SCREEN_HEIGHT));
   assign level     = is_volume ? volume_level : brightness_level;

   // Panel with rounded corners
   assign panel_box = (x_w >= CW'(PANEL_X)) && (x_w < CW'(PANEL_X + PANEL_W))
                      && (y_w >= CW'(PANEL_Y)) && (y_w < CW'(PANEL_Y + PANEL_H));
   assign lx = 6'(x_w - CW'(PANEL_X));
   assign ly = 7'(y_w - CW'(PANEL_Y));

   always_comb begin
      in_cx = 1'b1;
      in_cy = 1'b1;
      if (lx < 6'(CORNER)) begin
         cj = lx[2:0];
      end else if (lx >= 6'(PANEL_W - CORNER)) begin
         cj = 3'(6'(PANEL_W - 1) - lx);
      end else begin
         cj    = '0;
         in_cx = 1'b0;
      end
      if (ly < 7'(CORNER)) begin
         ci = ly[2:0];
      end else if (ly >= 7'(PANEL_H - CORNER)) begin
         ci = 3'(7'(PANEL_H - 1) - ly);
      end else begin
         ci    = '0;
         in_cy = 1'b0;
      end
   end

   assign cmask     = corner_bits(ci);
   assign panel_hit = panel_box && (!(in_cx && in_cy) || cmask[3'(CORNER - 1) - cj]);

   // Icon bitmap
   assign icon_box = (x_w >= CW'(ICON_X)) && (x_w < CW'(ICON_X + ICON_SIZE))
                     && (y_w >= CW'(ICON_Y)) && (y_w < CW'(ICON_Y + ICON_SIZE));
   assign ix   = 5'(x_w - CW'(ICON_X));
   assign iy   = 5'(y_w - CW'(ICON_Y));
   assign irow = is_volume ? speaker_row(iy) : sun_row(iy);
   assign ibit = 5'(ICON_SIZE - 1) - ix;

   // Bar boxes: one independent window compare per bar
   assign box_col = (x_w >= CW'(BOX_X)) && (x_w < CW'(BOX_X + BOX_W))
                    && (y_w >= CW'(BOX_Y));
   assign off     = Y_W'(y_w - CW'(BOX_Y));

   for (genvar k = 0; k < BAR_COUNT; k++) begin : g_bar
      localparam int LO = k * BOX_PITCH;
      assign bar_hits[k] = (off >= Y_W'(LO)) && (off < Y_W'(LO + BOX_H));
      assign bar_lit[k]  = (LEVEL_W'(BAR_COUNT - k) <= level);
   end

   always_comb begin
      hit.panel   = active && panel_hit;
      hit.icon    = active && icon_box && irow[ibit];
      hit.box     = active && box_col && (|bar_hits);
      hit.box_lit = |(bar_hits & bar_lit);
   end

endmodule

[hdl/osd_blend.sv]
// ----------------------------------------------------------------------------
// osd_blend
// Applies panel, icon and bar layers to the background color in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module osd_blend (
   input  logic [osd_pkg::COLOR_W-1:0] pixel_color,
   input  osd_pkg::osd_hit_type        hit,
   output logic [osd_pkg::COLOR_W-1:0] out_color
);
   import osd_pkg::*;

   logic [COLOR_W-1:0] c_panel;
   logic [COLOR_W-1:0] c_icon;

   assign c_panel = hit.panel ? darken(pixel_color) : pixel_color;
   assign c_icon  = hit.icon ? WHITE : c_panel;

   always_comb begin
      if (!hit.box) begin
         out_color = c_icon;
      end else if (hit.box_lit) begin
         out_color = WHITE;
      end else begin
         out_color = darken(c_icon);
      end
   end

endmodule
